// ===== src/assert_macros.svh =====
// =============================================================================
// assert_macros.svh
// Clocked assertion shorthands used by the top RTL file of the cache block.
// =============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check expr at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that ante at one edge implies cons at the same edge.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that ante at one edge implies cons at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lrc_pkg.sv =====
// =============================================================================
// lrc_pkg
// Shared sizes, codes and beat types of the LRU lookup cache.
// =============================================================================
package lrc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 64;
    localparam int ID_W    = 8;

    // operation codes carried in the command beat
    localparam logic [1:0] MODE_GET = 2'd0;
    localparam logic [1:0] MODE_PUT = 2'd1;
    localparam logic [1:0] MODE_INV = 2'd2;

    // kinds of rank update applied in the second pass
    localparam logic [1:0] UPD_TOUCH  = 2'd0;
    localparam logic [1:0] UPD_INSERT = 2'd1;
    localparam logic [1:0] UPD_DEC    = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  server_id;
    } t_cmd;

    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] found_id;
        logic            evicted;
    } t_result;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_target;
        logic       valid;
    } t_ent_ctl;

    typedef struct packed {
        logic              match;
        logic              above;
        logic [RANK_W-1:0] new_rank;
    } t_ent_eval;

endpackage

// ===== src/lrc_ram.sv =====
// =============================================================================
// lrc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// =============================================================================
module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lrc_entry_unit.sv =====
// =============================================================================
// lrc_entry_unit
// Shared per-entry datapath: key compare, rank compare and next-rank logic.
// =============================================================================
module lrc_entry_unit (
    input  lrc_pkg::t_ent_ctl                i_ctl,
    input  logic [lrc_pkg::KEY_W-1:0]        i_key,
    input  logic [lrc_pkg::KEY_W-1:0]        i_ent_key,
    input  logic [lrc_pkg::RANK_W-1:0]       i_rank,
    input  logic [lrc_pkg::RANK_W-1:0]       i_ref_rank,
    output lrc_pkg::t_ent_eval               o_eval
);

    logic                        w_above;
    logic                        w_below;
    logic [lrc_pkg::RANK_W-1:0]  w_inc;
    logic [lrc_pkg::RANK_W-1:0]  w_dec;
    logic [lrc_pkg::RANK_W-1:0]  w_new;

    assign w_above = i_rank > i_ref_rank;
    assign w_below = i_rank < i_ref_rank;
    assign w_inc   = i_rank + lrc_pkg::RANK_W'(1);
    assign w_dec   = i_rank - lrc_pkg::RANK_W'(1);

    always_comb begin
        w_new = i_rank;
        if (i_ctl.is_target) begin
            // the removed entry keeps its stale rank; a touched or inserted target goes to most recent
            w_new = (i_ctl.kind == lrc_pkg::UPD_DEC) ? i_rank : '0;
        end else if (i_ctl.valid) begin
            case (i_ctl.kind)
                lrc_pkg::UPD_TOUCH:  w_new = w_below ? w_inc : i_rank;
                lrc_pkg::UPD_INSERT: w_new = w_inc;
                lrc_pkg::UPD_DEC:    w_new = w_above ? w_dec : i_rank;
                default:             w_new = i_rank;
            endcase
        end
    end

    assign o_eval.match    = i_ctl.valid && (i_ent_key == i_key);
    assign o_eval.above    = w_above;
    assign o_eval.new_rank = w_new;

endmodule

// ===== src/lru_lookup_cache.sv =====
// Each command runs a scan pass over all entries, a decide step and, when ranks
// change, a rank-update pass before the o_done beat; a miss that changes nothing
// skips the rank-update pass. Each pass handles one entry per cycle, and a new
// command is accepted only in idle, after the o_done beat.
// busy stays high from acceptance through the o_done cycle; results cannot stall.
// Reset clears the valid bits at once, so no clearing pass is needed.
// =============================================================================
// lru_lookup_cache
// Fully associative key-to-server-id table with least-recently-used replacement.
// =============================================================================
`include "assert_macros.svh"

module lru_lookup_cache (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  lrc_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output lrc_pkg::t_result o_result
);

    localparam int ENTRIES = lrc_pkg::ENTRIES;
    localparam int IDX_W   = lrc_pkg::IDX_W;
    localparam int RANK_W  = lrc_pkg::RANK_W;
    localparam int CNT_W   = lrc_pkg::CNT_W;
    localparam int KV_W    = lrc_pkg::KEY_W + lrc_pkg::ID_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    // control state
    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_rv, n_rv;
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic [ENTRIES-1:0] r_valid, n_valid;

    // command and scan trackers
    lrc_pkg::t_cmd      r_cmd, n_cmd;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic [RANK_W-1:0]  r_hit_rank, n_hit_rank;
    logic [lrc_pkg::ID_W-1:0] r_hit_id, n_hit_id;
    logic               r_free_ok, n_free_ok;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;
    logic [RANK_W-1:0]  r_max_rank, n_max_rank;
    logic [IDX_W-1:0]   r_lru_idx, n_lru_idx;
    logic [IDX_W-1:0]   r_tgt_idx, n_tgt_idx;
    logic [RANK_W-1:0]  r_tgt_rank, n_tgt_rank;
    logic [1:0]         r_kind, n_kind;
    lrc_pkg::t_result   r_res, n_res;

    // datapath wires
    logic               w_rd_ok;
    logic [IDX_W-1:0]   w_raddr;
    logic               w_kv_we;
    logic [IDX_W-1:0]   w_kv_waddr;
    logic [KV_W-1:0]    w_kv_wdata;
    logic [KV_W-1:0]    w_kv_rdata;
    logic               w_rk_we;
    logic [RANK_W-1:0]  w_rk_rdata;
    logic [RANK_W-1:0]  w_ref_rank;
    logic               w_evict;
    lrc_pkg::t_ent_ctl  w_ctl;
    lrc_pkg::t_ent_eval w_eval;

    assign w_rd_ok = r_cnt < CNT_W'(ENTRIES);
    assign w_raddr = r_cnt[IDX_W-1:0];

    lrc_ram #(
        .WIDTH (KV_W),
        .DEPTH (ENTRIES)
    ) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (w_kv_we),
        .i_waddr (w_kv_waddr),
        .i_wdata (w_kv_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_kv_rdata)
    );

    lrc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_rk_we),
        .i_waddr (r_pidx),
        .i_wdata (w_eval.new_rank),
        .i_raddr (w_raddr),
        .o_rdata (w_rk_rdata)
    );

    assign w_ref_rank      = (r_state == ST_SCAN) ? r_max_rank : r_tgt_rank;
    assign w_ctl.kind      = r_kind;
    assign w_ctl.is_target = (r_pidx == r_tgt_idx);
    assign w_ctl.valid     = r_valid[r_pidx];

    lrc_entry_unit u_entry (
        .i_ctl      (w_ctl),
        .i_key      (r_cmd.key),
        .i_ent_key  (w_kv_rdata[KV_W-1 -: lrc_pkg::KEY_W]),
        .i_rank     (w_rk_rdata),
        .i_ref_rank (w_ref_rank),
        .o_eval     (w_eval)
    );

    assign w_rk_we = (r_state == ST_UPD) && r_rv;
    assign w_evict = (r_cmd.mode == lrc_pkg::MODE_PUT) && !r_hit && !r_free_ok;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_rv       = r_rv;
        n_pidx     = r_pidx;
        n_valid    = r_valid;
        n_cmd      = r_cmd;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_rank = r_hit_rank;
        n_hit_id   = r_hit_id;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_max_rank = r_max_rank;
        n_lru_idx  = r_lru_idx;
        n_tgt_idx  = r_tgt_idx;
        n_tgt_rank = r_tgt_rank;
        n_kind     = r_kind;
        n_res      = r_res;
        w_kv_we    = 1'b0;
        w_kv_waddr = r_tgt_idx;
        w_kv_wdata = {r_cmd.key, r_cmd.server_id};

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd      = i_cmd;
                    n_cnt      = '0;
                    n_rv       = 1'b0;
                    n_hit      = 1'b0;
                    n_free_ok  = 1'b0;
                    n_max_rank = '0;
                    n_lru_idx  = '0;
                    n_kind     = lrc_pkg::UPD_TOUCH;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_rv   = w_rd_ok;
                n_pidx = w_raddr;
                n_cnt  = r_cnt + CNT_W'(w_rd_ok);
                if (r_rv) begin
                    if (w_eval.match && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_pidx;
                        n_hit_rank = w_rk_rdata;
                        n_hit_id   = w_kv_rdata[lrc_pkg::ID_W-1:0];
                    end
                    if (!w_ctl.valid && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_pidx;
                    end
                    if (w_ctl.valid && w_eval.above) begin
                        n_max_rank = w_rk_rdata;
                        n_lru_idx  = r_pidx;
                    end
                end
                if (!w_rd_ok && r_rv) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_cnt   = '0;
                n_rv    = 1'b0;
                n_res   = '0;
                n_state = ST_RESP;
                case (r_cmd.mode)
                    lrc_pkg::MODE_GET: begin
                        if (r_hit) begin
                            n_res.hit      = 1'b1;
                            n_res.found_id = r_hit_id;
                            n_kind         = lrc_pkg::UPD_TOUCH;
                            n_tgt_idx      = r_hit_idx;
                            n_tgt_rank     = r_hit_rank;
                            n_state        = ST_UPD;
                        end
                    end
                    lrc_pkg::MODE_PUT: begin
                        if (r_hit) begin
                            n_res.hit      = 1'b1;
                            n_res.found_id = r_cmd.server_id;
                            n_kind         = lrc_pkg::UPD_TOUCH;
                            n_tgt_idx      = r_hit_idx;
                            n_tgt_rank     = r_hit_rank;
                        end else if (r_free_ok) begin
                            n_kind         = lrc_pkg::UPD_INSERT;
                            n_tgt_idx      = r_free_idx;
                            n_tgt_rank     = '0;
                        end else begin
                            n_res.evicted  = 1'b1;
                            n_kind         = lrc_pkg::UPD_TOUCH;
                            n_tgt_idx      = r_lru_idx;
                            n_tgt_rank     = r_max_rank;
                        end
                        // write the key and id now; the rank pass does not use them
                        w_kv_we            = 1'b1;
                        w_kv_waddr         = n_tgt_idx;
                        n_valid[n_tgt_idx] = 1'b1;
                        n_state            = ST_UPD;
                    end
                    lrc_pkg::MODE_INV: begin
                        if (r_hit) begin
                            n_res.hit          = 1'b1;
                            n_res.found_id     = r_hit_id;
                            n_kind             = lrc_pkg::UPD_DEC;
                            n_tgt_idx          = r_hit_idx;
                            n_tgt_rank         = r_hit_rank;
                            n_valid[r_hit_idx] = 1'b0;
                            n_state            = ST_UPD;
                        end
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end
            ST_UPD: begin
                n_rv   = w_rd_ok;
                n_pidx = w_raddr;
                n_cnt  = r_cnt + CNT_W'(w_rd_ok);
                if (!w_rd_ok && r_rv) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_pidx  <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rv    <= n_rv;
            r_pidx  <= n_pidx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_rank <= n_hit_rank;
        r_hit_id   <= n_hit_id;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_max_rank <= n_max_rank;
        r_lru_idx  <= n_lru_idx;
        r_tgt_idx  <= n_tgt_idx;
        r_tgt_rank <= n_tgt_rank;
        r_kind     <= n_kind;
        r_res      <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = (r_state == ST_RESP);
    assign o_result = r_res;

    `ASSERT_NEXT(a_done_single, o_done, !o_done, "done beat lasted more than one cycle")
    `ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
    `ASSERT_SAME(a_evict_full, (r_state == ST_DECIDE) && w_evict, &r_valid,
                 "eviction chosen while a free slot exists")
    `ASSERT_SAME(a_miss_zero, o_done && !o_result.hit, o_result.found_id == '0,
                 "miss reported a nonzero server id")
    `ASSERT_SAME(a_evict_miss, o_done && o_result.evicted, !o_result.hit,
                 "eviction reported together with a hit")

endmodule
